// ===== hw/rtl/scma_pkg.sv =====
`timescale 1ns / 1ps

package scma_pkg;

    // fixed field widths
    localparam int unsigned MODE_W = 2;
    localparam int unsigned CLS_W  = 5;
    localparam int unsigned PROB_W = 16;
    localparam int unsigned NCLS_W = 6;
    localparam int unsigned VAL_W  = 48;
    localparam int unsigned PSUM_W = 20;

    // shared multiplier: 17 bits covers a residual of exactly 1.0 and k up to 256
    localparam int unsigned MUL_W  = 17;
    localparam int unsigned PROD_W = 2 * MUL_W;
    // k*k for k up to 256
    localparam int unsigned KK_W   = 17;

    localparam int unsigned DEF_MAX_CLASSES = 32;
    localparam int unsigned DEF_LIST_DEPTH  = 8;

    localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = NCLS_W'(32);
    localparam logic [MUL_W-1:0]  ONE_Q16         = MUL_W'(65536);
    localparam logic [VAL_W-1:0]  VAL_MAX         = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef struct packed {
        logic mul_en;
        logic use_prod;
    } t_alu_ctl;

endpackage

// ===== hw/rtl/scma_alu.sv =====
`timescale 1ns / 1ps

module scma_alu (
    input  logic                        i_clk,
    input  scma_pkg::t_alu_ctl          i_ctl,
    input  logic [scma_pkg::MUL_W-1:0]  i_op_a,
    input  logic [scma_pkg::MUL_W-1:0]  i_op_b,
    input  logic [scma_pkg::VAL_W-1:0]  i_acc,
    input  logic [scma_pkg::VAL_W-1:0]  i_addend,
    output logic [scma_pkg::PROD_W-1:0] o_prod,
    output logic [scma_pkg::VAL_W-1:0]  o_sum
);
    import scma_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  addend;
    logic [VAL_W:0]    sum_ext;

    // registered product
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_op_a) * PROD_W'(i_op_b);
        end
    end

    // saturating accumulate
    always_comb begin
        addend  = i_ctl.use_prod ? VAL_W'(r_prod) : i_addend;
        sum_ext = (VAL_W + 1)'(i_acc) + (VAL_W + 1)'(addend);
        o_sum   = sum_ext[VAL_W] ? VAL_MAX : sum_ext[VAL_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/scma_div.sv =====
`timescale 1ns / 1ps

module scma_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [scma_pkg::VAL_W-1:0] i_dividend,
    input  logic [scma_pkg::KK_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [scma_pkg::VAL_W-1:0] o_quot
);
    import scma_pkg::*;

    localparam int unsigned CNT_W = $clog2(VAL_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_quot;
    logic [KK_W-1:0]  r_rem;
    logic [KK_W-1:0]  r_dvsr;

    logic [KK_W:0]    rem_sh;
    logic [KK_W+1:0]  diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_quot[VAL_W-1]};
        diff   = (KK_W + 2)'(rem_sh) - (KK_W + 2)'(r_dvsr);
        ge     = ~diff[KK_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VAL_W);
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvsr <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[VAL_W-2:0], ge};
                r_rem  <= ge ? diff[KK_W-1:0] : rem_sh[KK_W-1:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/soft_confusion_matrix_accumulator.sv =====
// Soft confusion matrix accumulator. Items arrive on a valid/stall channel and
// carry a mode: add one (class, probability) entry of a pixel's top-class list,
// read one finalized matrix entry, or clear all stores. One item is worked on at
// a time and o_in_stall stays high until it is done; a result item sits in an
// output register, so the next item can start while that result waits. The
// datapath is one shared multiply/saturating-add unit and a pair-sum memory
// with one write port and a registered read port. An add with n entries
// already in the list does n+1 read-modify-writes of the memory, plus the
// residual square and accumulate when the entry closes the list. A read is
// paced by the 48-step bit-serial divider that forms the residual share
// residual/(K*K). A clear, and the clearing pass that follows reset, sweeps
// all MAX_CLASSES*MAX_CLASSES memory entries one entry a cycle, during
// which no item is taken (num_classes writes are still taken). An
// entry whose class is at or beyond num_classes, and a read outside the K by K
// matrix, return one result with matrix_value 0 and index_error set; accepted
// add entries return nothing. num_classes of 0 acts as 1, values above
// MAX_CLASSES act as MAX_CLASSES; write it only while the block is idle.
`timescale 1ns / 1ps

module soft_confusion_matrix_accumulator #(
    parameter int unsigned MAX_CLASSES = scma_pkg::DEF_MAX_CLASSES,
    parameter int unsigned LIST_DEPTH  = scma_pkg::DEF_LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [scma_pkg::NCLS_W-1:0] i_cfg_wdata,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [scma_pkg::MODE_W-1:0] i_mode,
    input  logic [scma_pkg::CLS_W-1:0]  i_entry_class,
    input  logic [scma_pkg::PROB_W-1:0] i_entry_prob,
    input  logic                        i_last_entry,
    input  logic [scma_pkg::CLS_W-1:0]  i_read_row,
    input  logic [scma_pkg::CLS_W-1:0]  i_read_col,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [scma_pkg::VAL_W-1:0]  o_matrix_value,
    output logic                        o_index_error
);
    import scma_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_CLASSES);
    localparam int unsigned DEPTH = MAX_CLASSES * MAX_CLASSES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned LW    = $clog2(LIST_DEPTH + 1);
    localparam int unsigned IW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    // wide enough for num_classes and for MAX_CLASSES itself
    localparam int unsigned KW    = ($clog2(MAX_CLASSES + 1) > NCLS_W) ?
                                    $clog2(MAX_CLASSES + 1) : NCLS_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_ADD_PUSH,
        S_RES_MUL,
        S_RES_ADD,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RESULT
    } t_state;

    // row-major pair-sum address
    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col);
        f_addr = AW'(row) * AW'(MAX_CLASSES) + AW'(col);
    endfunction

    t_state              r_state;
    logic [NCLS_W-1:0]   r_num_classes;
    logic [AW-1:0]       r_clr;
    logic [AW-1:0]       r_addr;
    logic [LW-1:0]       r_cnt;
    logic [LW-1:0]       r_len;
    logic [PSUM_W-1:0]   r_psum;
    logic [VAL_W-1:0]    r_resid;
    logic [VAL_W-1:0]    r_val;
    logic                r_bad;
    logic [CW-1:0]       r_cls;
    logic [PROB_W-1:0]   r_prob;
    logic                r_last;
    logic [CW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       r_classes [LIST_DEPTH];
    logic [PROB_W-1:0]   r_probs   [LIST_DEPTH];
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic                r_out_err;

    // pair-sum memory
    logic [VAL_W-1:0]    r_pair_mem [DEPTH];
    logic [VAL_W-1:0]    r_rdata;

    logic [KW-1:0]       k_eff;
    logic                cls_bad;
    logic                rd_bad;
    logic                list_full;
    logic                psum_lt_one;
    logic [PSUM_W:0]     psum_ext;
    logic [PSUM_W-1:0]   n_psum;
    logic [IW-1:0]       list_idx;
    logic                res_load;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [VAL_W-1:0]    wr_data;
    logic                mem_we;
    t_alu_ctl            alu_ctl;
    logic [MUL_W-1:0]    op_a;
    logic [MUL_W-1:0]    op_b;
    logic [VAL_W-1:0]    acc;
    logic [VAL_W-1:0]    addend;
    logic [PROD_W-1:0]   alu_prod;
    logic [VAL_W-1:0]    alu_sum;
    logic                div_start;
    logic                div_done;
    logic [VAL_W-1:0]    div_quot;

    // effective class count
    always_comb begin
        if (r_num_classes == '0) begin
            k_eff = KW'(1);
        end else if (KW'(r_num_classes) > KW'(MAX_CLASSES)) begin
            k_eff = KW'(MAX_CLASSES);
        end else begin
            k_eff = KW'(r_num_classes);
        end
    end

    always_comb begin
        cls_bad     = KW'(i_entry_class) >= k_eff;
        rd_bad      = (KW'(i_read_row) >= k_eff) || (KW'(i_read_col) >= k_eff);
        list_full   = r_len == LW'(LIST_DEPTH);
        psum_lt_one = r_psum < PSUM_W'(ONE_Q16);
        psum_ext    = (PSUM_W + 1)'(r_psum) + (PSUM_W + 1)'(r_prob);
        n_psum      = psum_ext[PSUM_W] ? '1 : psum_ext[PSUM_W-1:0];
        list_idx    = r_cnt[IW-1:0];
    end

    // result register takes a new item once its slot is free
    assign res_load = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // datapath steering per sequencer step
    always_comb begin
        rd_addr   = r_addr;
        wr_addr   = r_addr;
        wr_data   = alu_sum;
        mem_we    = 1'b0;
        alu_ctl   = '0;
        op_a      = '0;
        op_b      = '0;
        acc       = r_val;
        addend    = r_rdata;
        div_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            S_ADD_RD: begin
                // earlier list entries first, then the entry with itself
                if (r_cnt < r_len) begin
                    rd_addr = f_addr(r_classes[list_idx], r_cls);
                    op_a    = MUL_W'(r_probs[list_idx]);
                end else begin
                    rd_addr = f_addr(r_cls, r_cls);
                    op_a    = MUL_W'(r_prob);
                end
                op_b           = MUL_W'(r_prob);
                alu_ctl.mul_en = 1'b1;
            end
            S_ADD_WR: begin
                mem_we           = 1'b1;
                acc              = r_rdata;
                alu_ctl.use_prod = 1'b1;
            end
            S_RES_MUL: begin
                op_a           = ONE_Q16 - r_psum[MUL_W-1:0];
                op_b           = ONE_Q16 - r_psum[MUL_W-1:0];
                alu_ctl.mul_en = 1'b1;
            end
            S_RES_ADD: begin
                acc              = r_resid;
                alu_ctl.use_prod = 1'b1;
            end
            S_RD_A: begin
                rd_addr        = f_addr(r_row, r_col);
                // k*k for the residual share
                op_a           = MUL_W'(k_eff);
                op_b           = MUL_W'(k_eff);
                alu_ctl.mul_en = 1'b1;
            end
            S_RD_B: begin
                rd_addr = f_addr(r_col, r_row);
            end
            S_RD_C: begin
                acc    = r_val;
                addend = r_rdata;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                acc    = r_val;
                addend = div_quot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pair_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_pair_mem[rd_addr];
    end

    scma_alu u_alu (
        .i_clk    (i_clk),
        .i_ctl    (alu_ctl),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_acc    (acc),
        .i_addend (addend),
        .o_prod   (alu_prod),
        .o_sum    (alu_sum)
    );

    scma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_resid),
        .i_divisor  (alu_prod[KK_W-1:0]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_num_classes <= NUM_CLASSES_RST;
            r_len         <= '0;
            r_psum        <= '0;
            r_resid       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_classes <= i_cfg_wdata;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_clr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cls  <= CW'(i_entry_class);
                        r_prob <= i_entry_prob;
                        r_last <= i_last_entry;
                        r_row  <= CW'(i_read_row);
                        r_col  <= CW'(i_read_col);
                        r_cnt  <= '0;
                        r_val  <= '0;
                        case (t_mode'(i_mode))
                            MODE_ADD: begin
                                r_bad <= cls_bad;
                                if (!cls_bad && !list_full) begin
                                    r_state <= S_ADD_RD;
                                end else if (i_last_entry) begin
                                    // dropped entry still closes the list
                                    r_state <= S_RES_MUL;
                                end else if (cls_bad) begin
                                    r_state <= S_RESULT;
                                end
                            end
                            MODE_READ: begin
                                r_bad   <= rd_bad;
                                r_state <= rd_bad ? S_RESULT : S_RD_A;
                            end
                            MODE_CLEAR: begin
                                r_bad   <= 1'b0;
                                r_resid <= '0;
                                r_len   <= '0;
                                r_psum  <= '0;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADD_RD: begin
                    r_addr  <= rd_addr;
                    r_state <= S_ADD_WR;
                end
                S_ADD_WR: begin
                    if (r_cnt == r_len) begin
                        r_state <= S_ADD_PUSH;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_ADD_RD;
                    end
                end
                S_ADD_PUSH: begin
                    r_classes[r_len[IW-1:0]] <= r_cls;
                    r_probs[r_len[IW-1:0]]   <= r_prob;
                    r_len                    <= r_len + 1'b1;
                    r_psum                   <= n_psum;
                    r_state                  <= r_last ? S_RES_MUL : S_IDLE;
                end
                S_RES_MUL: begin
                    if (psum_lt_one) begin
                        r_state <= S_RES_ADD;
                    end else begin
                        r_len   <= '0;
                        r_psum  <= '0;
                        r_state <= r_bad ? S_RESULT : S_IDLE;
                    end
                end
                S_RES_ADD: begin
                    r_resid <= alu_sum;
                    r_len   <= '0;
                    r_psum  <= '0;
                    r_state <= r_bad ? S_RESULT : S_IDLE;
                end
                S_RD_A: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_val   <= r_rdata;
                    r_state <= (r_row == r_col) ? S_DIV_GO : S_RD_C;
                end
                S_RD_C: begin
                    r_val   <= alu_sum;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_val   <= alu_sum;
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    // wait for the output slot to free up
                    if (res_load) begin
                        r_out_value <= r_val;
                        r_out_err   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_matrix_value = r_out_value;
    assign o_index_error  = r_out_err;

endmodule

// ===== hw/rtl/scma_chk.sv =====
`timescale 1ns / 1ps

module scma_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [scma_pkg::MODE_W-1:0] i_mode,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [scma_pkg::VAL_W-1:0]  o_matrix_value,
    input logic                        o_index_error
);
    import scma_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_matrix_value) && $stable(o_index_error))
        else $error("result item changed while stalled");

    // reset starts the clearing pass with no result pending
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("not busy and empty after reset");

    // a taken read or clear item holds off the input channel
    a_multi_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (t_mode'(i_mode) == MODE_READ || t_mode'(i_mode) == MODE_CLEAR)
        |=> o_in_stall)
        else $error("read or clear item did not hold off input");

    // an index error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_matrix_value == '0)
        else $error("index error with nonzero value");

endmodule

bind soft_confusion_matrix_accumulator scma_chk u_scma_chk (.*);

// ===== sim/scma_result_checker.sv =====
`timescale 1ns / 1ps

module scma_result_checker #(
    parameter int unsigned MAX_CLASSES = scma_pkg::DEF_MAX_CLASSES,
    parameter int unsigned LIST_DEPTH  = scma_pkg::DEF_LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scma_pkg::NCLS_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [scma_pkg::MODE_W-1:0] i_mode,
    input  logic [scma_pkg::CLS_W-1:0]  i_entry_class,
    input  logic [scma_pkg::PROB_W-1:0] i_entry_prob,
    input  logic                        i_last_entry,
    input  logic [scma_pkg::CLS_W-1:0]  i_read_row,
    input  logic [scma_pkg::CLS_W-1:0]  i_read_col,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [scma_pkg::VAL_W-1:0]  i_matrix_value,
    input  logic                        i_index_error,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    import scma_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             index_error;
    } t_cell_reading;

    logic [VAL_W-1:0]  cell_sum [MAX_CLASSES*MAX_CLASSES];
    logic [CLS_W-1:0]  kept_class [LIST_DEPTH];
    logic [PROB_W-1:0] kept_prob [LIST_DEPTH];
    int unsigned       kept_count = 0;
    logic [PSUM_W-1:0] prob_total = '0;
    logic [VAL_W-1:0]  residual_acc = '0;
    logic [NCLS_W-1:0] class_count = NUM_CLASSES_RST;
    t_cell_reading     awaited_readings [$];
    int                mismatches = 0;
    int                readings_checked = 0;

    function automatic logic [VAL_W-1:0] clamp_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'(VAL_MAX)) ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    function automatic int unsigned classes_in_use();
        if (class_count == 0) return 1;
        if (class_count > MAX_CLASSES) return MAX_CLASSES;
        return class_count;
    endfunction

    // queue one predicted result item at the tail
    function automatic void await_reading(logic [VAL_W-1:0] value, logic index_error);
        t_cell_reading reading;
        reading.value       = value;
        reading.index_error = index_error;
        awaited_readings.insert(awaited_readings.size(), reading);
    endfunction

    function automatic void clear_stores();
        foreach (cell_sum[j]) cell_sum[j] = '0;
        residual_acc = '0;
        kept_count   = 0;
        prob_total   = '0;
    endfunction

    // squared shortfall of the list below 1.0 goes into the residual
    function automatic void close_pixel();
        logic [63:0] shortfall;
        if (prob_total < PSUM_W'(ONE_Q16)) begin
            shortfall    = 64'(ONE_Q16) - 64'(prob_total);
            residual_acc = clamp_add(residual_acc, shortfall * shortfall);
        end
        kept_count = 0;
        prob_total = '0;
    endfunction

    function automatic void take_entry(logic [CLS_W-1:0] cls, logic [PROB_W-1:0] prob,
                                       logic last);
        int unsigned     k;
        int unsigned     i;
        int unsigned     at;
        logic [PSUM_W:0] total;
        k = classes_in_use();
        if (cls < k && kept_count < LIST_DEPTH) begin
            for (i = 0; i < kept_count; i++) begin
                at = kept_class[i] * MAX_CLASSES + cls;
                cell_sum[at] = clamp_add(cell_sum[at], 64'(kept_prob[i]) * 64'(prob));
            end
            at = cls * MAX_CLASSES + cls;
            cell_sum[at] = clamp_add(cell_sum[at], 64'(prob) * 64'(prob));
            kept_class[kept_count] = cls;
            kept_prob[kept_count]  = prob;
            kept_count++;
            total      = prob_total + prob;
            prob_total = total[PSUM_W] ? '1 : total[PSUM_W-1:0];
        end
        if (last) close_pixel();
        if (cls >= k) await_reading('0, 1'b1);
    endfunction

    function automatic void read_cell(logic [CLS_W-1:0] row, logic [CLS_W-1:0] col);
        int unsigned k;
        logic [63:0] total;
        k = classes_in_use();
        if (row >= k || col >= k) begin
            await_reading('0, 1'b1);
        end else begin
            total = cell_sum[row * MAX_CLASSES + col];
            if (row != col) total = clamp_add(total, cell_sum[col * MAX_CLASSES + row]);
            total = clamp_add(total, 64'(residual_acc) / 64'(k * k));
            await_reading(total[VAL_W-1:0], 1'b0);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_cell_reading want;
        if (!i_rst_n) begin
            clear_stores();
            class_count = NUM_CLASSES_RST;
            awaited_readings.delete();
        end else begin
            // results first: nothing accepted at this edge can already be out
            if (i_out_valid && !i_out_stall) begin
                if (awaited_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected item value=%h index_error=%b",
                                              i_matrix_value, i_index_error));
                end else begin
                    want = awaited_readings.pop_front();
                    readings_checked++;
                    if (i_matrix_value !== want.value)
                        report_mismatch($sformatf("matrix_value %h, expected %h",
                                                  i_matrix_value, want.value));
                    if (i_index_error !== want.index_error)
                        report_mismatch($sformatf("index_error %b, expected %b",
                                                  i_index_error, want.index_error));
                end
            end
            if (i_cfg_we) class_count = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    MODE_ADD:   take_entry(i_entry_class, i_entry_prob, i_last_entry);
                    MODE_READ:  read_cell(i_read_row, i_read_col);
                    MODE_CLEAR: clear_stores();
                    default: ;
                endcase
            end
        end
        o_pending    <= awaited_readings.size();
        o_fail_count <= mismatches;
        o_checked    <= readings_checked;
    end

endmodule

// ===== sim/soft_confusion_matrix_accumulator_tb.sv =====
`timescale 1ns / 1ps

module soft_confusion_matrix_accumulator_tb;

    import scma_pkg::*;

    // mode 3 has no meaning, the block should drop it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    // a clear sweeps the whole 32x32 store one entry a cycle
    localparam int unsigned SETTLE_CYCLES = 1200;
    // full lists of 1.0 at one class, piling large sums onto one diagonal cell
    localparam int unsigned HEAVY_LISTS   = 20;
    localparam int unsigned PHASE_ITEMS   = 150;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [NCLS_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [MODE_W-1:0] i_mode = MODE_ADD;
    logic [CLS_W-1:0]  i_entry_class = '0;
    logic [PROB_W-1:0] i_entry_prob = '0;
    logic              i_last_entry = 1'b0;
    logic [CLS_W-1:0]  i_read_row = '0;
    logic [CLS_W-1:0]  i_read_col = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [VAL_W-1:0]  o_matrix_value;
    logic              o_index_error;

    int                fail_count;
    int                pending;
    int                checked;

    int unsigned       cycle_count = 0;
    int unsigned       source_max_gap = 15;
    int unsigned       sink_max_gap = 15;
    int unsigned       sink_hold_cycles = 0;
    int unsigned       k_now = DEF_MAX_CLASSES;
    int unsigned       adds_sent = 0;
    int unsigned       reads_sent = 0;
    int unsigned       clears_sent = 0;
    int unsigned       ignored_sent = 0;
    int unsigned       settings_used = 0;

    // class counts for the random phases: 0 and 63 check the clamping of K
    logic [NCLS_W-1:0] phase_classes [8] =
        '{6'd7, 6'd0, 6'd63, 6'd2, 6'd1, 6'd33, 6'd17, 6'd32};

    soft_confusion_matrix_accumulator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_entry_class  (i_entry_class),
        .i_entry_prob   (i_entry_prob),
        .i_last_entry   (i_last_entry),
        .i_read_row     (i_read_row),
        .i_read_col     (i_read_col),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_matrix_value (o_matrix_value),
        .o_index_error  (o_index_error)
    );

    // predicts every result item and compares it as it leaves the block
    scma_result_checker u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_entry_class  (i_entry_class),
        .i_entry_prob   (i_entry_prob),
        .i_last_entry   (i_last_entry),
        .i_read_row     (i_read_row),
        .i_read_col     (i_read_col),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_matrix_value (o_matrix_value),
        .i_index_error  (o_index_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake or a lost result ends here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d result items still awaited",
                 cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall before every item, plus one long hold-off on request
    initial begin : result_sink
        int unsigned pause;
        wait (i_rst_n);
        forever begin
            if (sink_hold_cycles != 0) begin
                pause = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                pause = $urandom_range(0, sink_max_gap);
            end
            if (pause != 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            // take exactly one item, sampled before this edge's updates
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // one item on the input channel; called at a clock edge, returns at the
    // edge where the item was taken, with valid still up
    task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [CLS_W-1:0] cls,
                              input logic [PROB_W-1:0] prob, input logic last,
                              input logic [CLS_W-1:0] row, input logic [CLS_W-1:0] col);
        int unsigned gap;
        gap = $urandom_range(0, source_max_gap);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_entry_class <= cls;
        i_entry_prob  <= prob;
        i_last_entry  <= last;
        i_read_row    <= row;
        i_read_col    <= col;
        do @(posedge i_clk); while (o_in_stall);
        case (mode)
            MODE_ADD:   adds_sent++;
            MODE_READ:  reads_sent++;
            MODE_CLEAR: clears_sent++;
            default:    ignored_sent++;
        endcase
    endtask

    // fields a mode does not use get random bits anyway
    task automatic push_entry(input logic [CLS_W-1:0] cls, input logic [PROB_W-1:0] prob,
                              input logic last);
        offer_item(MODE_ADD, cls, prob, last, CLS_W'($urandom), CLS_W'($urandom));
    endtask

    task automatic ask_cell(input logic [CLS_W-1:0] row, input logic [CLS_W-1:0] col);
        offer_item(MODE_READ, CLS_W'($urandom), PROB_W'($urandom), 1'($urandom), row, col);
    endtask

    task automatic offer_noise(input logic [MODE_W-1:0] mode);
        offer_item(mode, CLS_W'($urandom), PROB_W'($urandom), 1'($urandom),
                   CLS_W'($urandom), CLS_W'($urandom));
    endtask

    // mostly inside the current K, now and then any 5-bit index
    function automatic logic [CLS_W-1:0] pick_index();
        if ($urandom_range(0, 7) == 0) return CLS_W'($urandom);
        return CLS_W'($urandom_range(0, k_now - 1));
    endfunction

    // stop sending, wait for every awaited result, then give the block time to
    // finish an item that returns nothing (a clear is the slowest)
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_class_count(input logic [NCLS_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        k_now = (value == 0) ? 1 : (value > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : value;
        settings_used++;
    endtask

    // one pixel's list: usually a softmax-like split of 1.0, sometimes raw
    // 16-bit values or extremes; some lists run past the list store
    task automatic random_pixel();
        int unsigned       len;
        int unsigned       style;
        int unsigned       left;
        int unsigned       i;
        logic [PROB_W-1:0] prob;
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 6);
        style = $urandom_range(0, 3);
        left  = 65536;
        for (i = 0; i < len; i++) begin
            case (style)
                0, 1: begin
                    prob = PROB_W'($urandom_range(0, (left > 65535) ? 65535 : left));
                    left -= prob;
                end
                2:       prob = PROB_W'($urandom);
                default: prob = ($urandom_range(0, 1) != 0) ? '1 : '0;
            endcase
            // a read in the middle of an open list must not disturb it
            if ($urandom_range(0, 9) == 0) ask_cell(pick_index(), pick_index());
            push_entry(pick_index(), prob, i == len - 1);
        end
    endtask

    // ignored mode-3 items do not count toward the quota
    task automatic random_traffic(input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        start = adds_sent + reads_sent + clears_sent;
        while (adds_sent + reads_sent + clears_sent - start < quota) begin
            pick = $urandom_range(0, 199);
            if (pick < 90)       random_pixel();
            else if (pick < 190) ask_cell(pick_index(), pick_index());
            else if (pick < 198) offer_noise(MODE_UNUSED);
            else                 offer_noise(MODE_CLEAR);
        end
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned j;
        int unsigned phase;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, K at its reset value of 32; the first item waits out
        // the clearing pass after reset
        ask_cell(5'd0, 5'd31);                  // empty store
        push_entry(5'd0, 16'hFFFF, 1'b0);
        push_entry(5'd31, 16'h0000, 1'b0);
        push_entry(5'd0, 16'h0001, 1'b1);       // class repeated, sum exactly 1.0
        push_entry(5'd7, 16'h4000, 1'b1);       // lone entry leaves a residual
        ask_cell(5'd31, 5'd0);
        ask_cell(5'd7, 5'd7);
        ask_cell(5'd0, 5'd0);
        for (j = 0; j <= DEF_LIST_DEPTH; j++)   // the last entry finds the list full
            push_entry(CLS_W'(j), 16'h1000, j == DEF_LIST_DEPTH);
        offer_noise(MODE_UNUSED);
        offer_noise(MODE_CLEAR);
        ask_cell(5'd8, 5'd8);

        // directed, small K: out-of-range classes and reads
        set_class_count(6'd5);
        push_entry(5'd2, 16'h8000, 1'b0);
        push_entry(5'd31, 16'hFFFF, 1'b1);      // rejected but still closes the list
        push_entry(5'd5, 16'h1234, 1'b1);       // empty list closed, residual exactly 1.0
        ask_cell(5'd4, 5'd5);
        ask_cell(5'd2, 5'd2);

        // K=1, back-to-back full lists of 1.0 on class 0 pile up in cell (0,0)
        set_class_count(6'd1);
        source_max_gap = 0;
        offer_noise(MODE_CLEAR);
        for (n = 0; n < HEAVY_LISTS; n++) begin
            for (j = 0; j < DEF_LIST_DEPTH; j++)
                push_entry('0, '1, j == DEF_LIST_DEPTH - 1);
            if (n % 5 == 0 || n + 1 == HEAVY_LISTS) ask_cell('0, '0);
        end

        // random phases, each under its own K and idling pattern
        for (phase = 0; phase < 8; phase++) begin
            set_class_count(phase_classes[phase]);
            case (phase % 4)
                0: begin source_max_gap = 15; sink_max_gap = 15; end
                1: begin source_max_gap = 0;  sink_max_gap = 0;  end
                2: begin source_max_gap = 15; sink_max_gap = 0;  end
                default: begin source_max_gap = 0; sink_max_gap = 15; end
            endcase
            // back pressure: the sink holds off while items keep coming
            if (phase == 2) begin
                source_max_gap   = 0;
                sink_hold_cycles = 400;
            end
            random_traffic(PHASE_ITEMS);
        end

        settle();
        $display("sent %0d entries, %0d reads, %0d clears and %0d unused-mode items",
                 adds_sent, reads_sent, clears_sent, ignored_sent);
        $display("under %0d K settings; %0d result items compared, %0d mismatches, %0d awaited",
                 settings_used, checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/scma_pkg.sv
hw/rtl/scma_alu.sv
hw/rtl/scma_div.sv
hw/rtl/soft_confusion_matrix_accumulator.sv
hw/rtl/scma_chk.sv
sim/scma_result_checker.sv
sim/soft_confusion_matrix_accumulator_tb.sv
